FILE: rtl/core/rtbs_pkg.sv
`default_nettype none

package rtbs_pkg;

    localparam int ADDR_W      = 64;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int S_TDATA_W   = 80;  // entry_index + address, padded to bytes
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 16;  // match_index, padded to bytes
    localparam int M_TUSER_W   = 1;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/rtbs_ram.sv
`default_nettype none

module rtbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/range_table_binary_search.sv
// Range table lookup. The table holds TABLE_DEPTH 64-bit start addresses,
// expected strictly increasing; entry i covers start[i] <= a < start[i+1] and
// the last searched entry covers everything at or above its start. A write
// transaction (tuser = 0) stores one start address and returns nothing; the
// block stays ready for the next transaction. A lookup transaction (tuser = 1)
// binary-searches the first entry_count entries (saturated at TABLE_DEPTH) and
// returns found in tuser and the covering index in tdata. A lookup occupies the
// block until its result is moved to the output register; each probe reads the
// table RAM, whose registered output feeds the compare that picks the next
// probe address. The table is kept in two RAM copies, the second shifted
// down by one entry, so that start[mid] and start[mid+1] arrive in the same
// cycle. A finished result waits in the output register while the next
// transaction is taken. Entries read by a lookup must have been written first;
// there is no clearing pass. The user must write entry_count through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
`default_nettype none

module range_table_binary_search
    import rtbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CNT_W-1:0]     cfg_wdata,      // entry_count
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [9:0] entry_index, [73:10] address
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,   // [0] func
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,   // [9:0] match_index
    output logic      [M_TUSER_W-1:0] m_axis_tuser    // [0] found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (CW > CNT_W) ? CW : CNT_W;
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SRCH = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] entry_count_reg;
    logic             m_valid_reg, m_valid_next;

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hip1_reg, hip1_next;   // one past the upper bound
    logic [CW-1:0]     n_reg, n_next;
    logic [AW-1:0]     mid_reg, mid_next;
    logic              res_found_reg, res_found_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              m_found_reg, m_found_next;
    logic [IDX_W-1:0]  m_idx_reg, m_idx_next;

    logic              in_acc;
    logic              in_func;
    logic [IDX_W-1:0]  in_idx;
    logic [ADDR_W-1:0] in_addr;
    logic [NW-1:0]     cnt_ext;
    logic [CW-1:0]     n_cur;
    logic [CW:0]       s0;
    logic [XW-1:0]     idx_ext;
    logic              idx_ok;
    logic              wr_a_en, wr_b_en;
    logic [AW-1:0]     wr_a_addr, wr_b_addr;
    logic [AW-1:0]     raddr;
    logic [ADDR_W-1:0] tab_mid, tab_nxt;

    logic              last, ge, gt, lt_next;
    logic [CW-1:0]     mid_c, mid_p1, lo_n, hi_n;
    logic [CW:0]       sum;
    logic [XW-1:0]     mid_x;
    logic              out_free;

    // Copy A: start[i] at i. Copy B: start[i] at i-1, so B[mid] = start[mid+1].
    rtbs_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (wr_a_en),
        .waddr (wr_a_addr),
        .wdata (in_addr),
        .raddr (raddr),
        .rdata (tab_mid)
    );

    rtbs_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (wr_b_en),
        .waddr (wr_b_addr),
        .wdata (in_addr),
        .raddr (raddr),
        .rdata (tab_nxt)
    );

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        in_acc        = s_axis_tvalid && s_axis_tready;
        in_func       = s_axis_tuser[0];
        in_idx        = s_axis_tdata[IDX_W-1:0];
        in_addr       = s_axis_tdata[IDX_W +: ADDR_W];

        cnt_ext = NW'(entry_count_reg);
        n_cur   = (32'(cnt_ext) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : cnt_ext[CW-1:0];
        s0      = {1'b0, n_cur} - (CW+1)'(1);

        idx_ext   = XW'(in_idx);
        idx_ok    = (32'(in_idx) < TABLE_DEPTH);
        wr_a_en   = in_acc && (in_func == FUNC_WRITE) && idx_ok;
        wr_b_en   = wr_a_en && (in_idx != '0);
        wr_a_addr = idx_ext[AW-1:0];
        wr_b_addr = wr_a_addr - AW'(1);

        // probe evaluation
        mid_c   = CW'(mid_reg);
        last    = (mid_c == n_reg - CW'(1));
        ge      = (tab_mid <= addr_reg);
        gt      = (addr_reg > tab_mid);
        lt_next = (addr_reg < tab_nxt);
        mid_p1  = mid_c + CW'(1);
        lo_n    = gt ? mid_p1 : lo_reg;
        hi_n    = gt ? hip1_reg : mid_c;
        sum     = {1'b0, lo_n} + {1'b0, hi_n} - (CW+1)'(1);
        mid_x   = XW'(mid_reg);

        raddr = (state_reg == ST_IDLE) ? s0[AW:1] : sum[AW:1];

        out_free = !m_valid_reg || m_axis_tready;

        state_next     = state_reg;
        addr_next      = addr_reg;
        lo_next        = lo_reg;
        hip1_next      = hip1_reg;
        n_next         = n_reg;
        mid_next       = mid_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        m_found_next   = m_found_reg;
        m_idx_next     = m_idx_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_func == FUNC_LOOKUP))
                begin
                    addr_next = in_addr;
                    lo_next   = '0;
                    hip1_next = n_cur;
                    n_next    = n_cur;
                    mid_next  = raddr;
                    if (n_cur == '0)
                    begin
                        res_found_next = 1'b0;
                        res_idx_next   = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH:
            begin
                if (last)
                begin
                    res_found_next = ge;
                    res_idx_next   = ge ? mid_x[IDX_W-1:0] : '0;
                    state_next     = ST_DONE;
                end
                else if (ge && lt_next)
                begin
                    res_found_next = 1'b1;
                    res_idx_next   = mid_x[IDX_W-1:0];
                    state_next     = ST_DONE;
                end
                else if (lo_n >= hi_n)
                begin
                    res_found_next = 1'b0;
                    res_idx_next   = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    lo_next   = lo_n;
                    hip1_next = hi_n;
                    mid_next  = raddr;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_idx_next   = res_idx_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        lo_reg        <= lo_next;
        hip1_reg      <= hip1_next;
        n_reg         <= n_next;
        mid_reg       <= mid_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        m_found_reg   <= m_found_next;
        m_idx_reg     <= m_idx_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_idx_reg);
    assign m_axis_tuser  = M_TUSER_W'(m_found_reg);

endmodule

`default_nettype wire

FILE: rtl/core/rtbs_checker.sv
`default_nettype none

module rtbs_checker
    import rtbs_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cfg_we,
    input wire logic [CNT_W-1:0]     cfg_wdata,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [S_TUSER_W-1:0] s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == 1'b0) |-> m_axis_tdata == '0)
        else $error("not-found result carries a nonzero index");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> CNT_W'(m_axis_tdata[IDX_W-1:0]) < count_reg)
        else $error("found index outside the searched entries");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_LOOKUP) |=>
            !s_axis_tready)
        else $error("lookup did not occupy the block");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_WRITE) &&
            !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("write transaction produced a result");

endmodule

bind range_table_binary_search rtbs_checker u_rtbs_checker (.*);

`default_nettype wire
